/* rtl/core/aoha_pkg.sv */
// Shared constants, types and control bundle for the address-ordered heap allocator.
// No dependencies; used by aoha_cell and address_ordered_heap_allocator_core.
package aoha_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 24;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);

    localparam logic [31:0] FIRST_BLOCK_BYTES = 32'h0000_1000;
    localparam logic [31:0] HEAP_SIZE_RESET   = 32'd1048576;
    localparam logic [31:0] HDR32             = 32'(HEADER_BYTES);

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_RESERVE = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_INS  = 2'd1,
        OP_DEL  = 2'd2
    } cell_op_t;

    // Flags and values a cell reports into the scan line.
    typedef struct packed {
        logic        gap;         // new block fits between this entry and the next
        logic        alloc_last;  // new block fits after this entry, which is the last
        logic        match;       // header offset matches, entry may be freed
        logic        between;     // reserve header lies strictly between this and the next
        logic        rok;         // reserve fits after this entry
        logic        last;        // this entry is the last valid one
        logic [33:0] blk_end;     // header offset + header + payload
        logic [31:0] size;        // payload bytes
    } scan_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        cell_op_t         op;
        logic             load;
        logic             shift;
        logic [IDX_W-1:0] pos;
        logic [31:0]      new_start;
        logic [31:0]      new_size;
        logic [CNT_W-1:0] count;
        logic [32:0]      need;
        logic [31:0]      hdr;
        logic [31:0]      req;
        logic [31:0]      heap;
    } ctl_t;

endpackage

/* rtl/core/address_ordered_heap_allocator_core.sv */
// Top level of the address-ordered heap allocator (after last block, else first gap):
// controller, totals, result register, aoha_cell chain. Depends on aoha_pkg, aoha_cell.
//
//  channel | direction | handshake            | content
//  s_      | in        | s_tvalid / s_tready  | command transaction (tuser cmd, tdata offsets)
//  m_      | out       | m_tvalid / m_tready  | result transaction (ok, offset, used, available)
//  cfg_    | in        | cfg_valid / cfg_ready| heap_size register write
//
// A command runs through these steps in order: the command is registered, every cell
// evaluates its flags, the flags shift toward the head of the chain entry by entry,
// the table shifts for an insert or removal, and the result register is loaded.
// Commands that fail their early checks skip the scan. Reset is synchronous and
// leaves one reserved block at offset 0. A stalled result holds the next command
// in its final state until the result register frees.
module address_ordered_heap_allocator_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // [31:0] user_offset, [63:32] request_bytes
    input  logic [1:0]   s_tuser,   // [1:0] cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // [0] ok, [32:1] result_offset, [64:33] used_bytes,
                                    // [96:65] available_bytes, [103:97] zero
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_wdata
);
    import aoha_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_SCAN, ST_APPLY, ST_DONE
    } state_t;

    state_t           state_reg;
    cmd_t             cmd_reg;
    logic [31:0]      uoff_reg, req_reg, hdr_reg, heap_reg;
    logic [32:0]      need_reg;
    logic [CNT_W-1:0] count_reg;
    logic [31:0]      used_reg;
    logic [IDX_W-1:0] k_reg;
    logic             gap_found_reg;
    logic [IDX_W-1:0] gap_pos_reg;
    logic [31:0]      gap_start_reg;
    cell_op_t         op_reg;
    logic [IDX_W-1:0] pos_reg;
    logic [31:0]      new_start_reg, new_size_reg;
    logic             ok_reg;
    logic [31:0]      res_reg;
    logic             m_valid_reg;
    logic [96:0]      m_data_reg;

    ctl_t             ctl;
    logic [31:0]      start_w [MAX_BLOCKS];
    logic [31:0]      size_w  [MAX_BLOCKS];
    scan_t            scan_w  [MAX_BLOCKS];
    scan_t            head;
    logic             s_acc;
    logic [32:0]      res_sum;
    logic [32:0]      ins_used;
    logic [32:0]      del_d;
    logic [31:0]      avail;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_acc     = s_tvalid && s_tready;
    assign head      = scan_w[0];
    assign res_sum   = {1'b0, s_tdata[31:0]} + {1'b0, s_tdata[63:32]};
    assign ins_used  = {1'b0, used_reg} + {1'b0, HDR32} + {1'b0, new_size_reg};
    assign del_d     = {1'b0, HDR32} + {1'b0, new_size_reg};
    assign avail     = (heap_reg >= used_reg) ? (heap_reg - used_reg) : 32'd0;

    always_comb begin
        ctl           = '0;
        ctl.op        = op_reg;
        ctl.load      = (state_reg == ST_LOAD);
        ctl.shift     = (state_reg == ST_SCAN);
        ctl.pos       = pos_reg;
        ctl.new_start = new_start_reg;
        ctl.new_size  = new_size_reg;
        ctl.count     = count_reg;
        ctl.need      = need_reg;
        ctl.hdr       = hdr_reg;
        ctl.req       = req_reg;
        ctl.heap      = heap_reg;
    end

    // The chain: each cell sees its left and right neighbor; the ends see zeros.
    for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
        logic [31:0] l_start, l_size, r_start, r_size;
        scan_t       r_scan;
        if (i == 0) begin : g_first
            assign l_start = '0;
            assign l_size  = '0;
        end else begin : g_mid_l
            assign l_start = start_w[i-1];
            assign l_size  = size_w[i-1];
        end
        if (i == MAX_BLOCKS - 1) begin : g_last
            assign r_start = '0;
            assign r_size  = '0;
            assign r_scan  = '0;
        end else begin : g_mid_r
            assign r_start = start_w[i+1];
            assign r_size  = size_w[i+1];
            assign r_scan  = scan_w[i+1];
        end
        aoha_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .idx         (IDX_W'(i)),
            .init_size   ((i == 0) ? FIRST_BLOCK_BYTES : 32'd0),
            .ctl         (ctl),
            .left_start  (l_start),
            .left_size   (l_size),
            .right_start (r_start),
            .right_size  (r_size),
            .right_scan  (r_scan),
            .start       (start_w[i]),
            .size        (size_w[i]),
            .scan        (scan_w[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            heap_reg      <= HEAP_SIZE_RESET;
            count_reg     <= CNT_W'(1);
            used_reg      <= HDR32 + FIRST_BLOCK_BYTES;
            op_reg        <= OP_HOLD;
            m_valid_reg   <= 1'b0;
            gap_found_reg <= 1'b0;
            k_reg         <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                heap_reg <= cfg_wdata;
            end
            // The done state reloads the result register itself in the same cycle.
            if (m_valid_reg && m_tready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        cmd_reg       <= cmd_t'(s_tuser);
                        uoff_reg      <= s_tdata[31:0];
                        req_reg       <= s_tdata[63:32];
                        hdr_reg       <= s_tdata[31:0] - HDR32;
                        need_reg      <= {1'b0, HDR32} + {1'b0, s_tdata[63:32]};
                        new_size_reg  <= s_tdata[63:32];
                        k_reg         <= '0;
                        gap_found_reg <= 1'b0;
                        ok_reg        <= 1'b0;
                        res_reg       <= '0;
                        state_reg     <= ST_LOAD;
                        // Early rejects: unknown command, full table, offset under
                        // the header, reserve reaching the heap limit.
                        unique case (cmd_t'(s_tuser))
                            CMD_ALLOC: begin
                                if (count_reg >= CNT_W'(MAX_BLOCKS)) state_reg <= ST_DONE;
                            end
                            CMD_FREE: begin
                                if (s_tdata[31:0] < HDR32) state_reg <= ST_DONE;
                            end
                            CMD_RESERVE: begin
                                if (count_reg >= CNT_W'(MAX_BLOCKS) ||
                                    res_sum >= {1'b0, heap_reg} ||
                                    s_tdata[31:0] < HDR32) begin
                                    state_reg <= ST_DONE;
                                end
                            end
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_LOAD: begin
                    state_reg <= ST_SCAN;
                end
                ST_SCAN: begin
                    k_reg <= k_reg + IDX_W'(1);
                    case (cmd_reg)
                        CMD_ALLOC: begin
                            if (head.last) begin
                                if (head.alloc_last) begin
                                    op_reg        <= OP_INS;
                                    pos_reg       <= k_reg + IDX_W'(1);
                                    new_start_reg <= head.blk_end[31:0];
                                    res_reg       <= head.blk_end[31:0] + HDR32;
                                    ok_reg        <= 1'b1;
                                    state_reg     <= ST_APPLY;
                                end else if (gap_found_reg) begin
                                    op_reg        <= OP_INS;
                                    pos_reg       <= gap_pos_reg;
                                    new_start_reg <= gap_start_reg;
                                    res_reg       <= gap_start_reg + HDR32;
                                    ok_reg        <= 1'b1;
                                    state_reg     <= ST_APPLY;
                                end else begin
                                    state_reg <= ST_DONE;
                                end
                            end else if (head.gap && !gap_found_reg) begin
                                gap_found_reg <= 1'b1;
                                gap_pos_reg   <= k_reg + IDX_W'(1);
                                gap_start_reg <= head.blk_end[31:0];
                            end
                        end
                        CMD_FREE: begin
                            if (head.match) begin
                                op_reg       <= OP_DEL;
                                pos_reg      <= k_reg;
                                new_size_reg <= head.size;
                                res_reg      <= uoff_reg;
                                ok_reg       <= 1'b1;
                                state_reg    <= ST_APPLY;
                            end else if (head.last) begin
                                state_reg <= ST_DONE;
                            end
                        end
                        default: begin
                            if (head.between || head.last) begin
                                if (head.rok) begin
                                    op_reg        <= OP_INS;
                                    pos_reg       <= k_reg + IDX_W'(1);
                                    new_start_reg <= hdr_reg;
                                    res_reg       <= uoff_reg;
                                    ok_reg        <= 1'b1;
                                    state_reg     <= ST_APPLY;
                                end else begin
                                    state_reg <= ST_DONE;
                                end
                            end
                        end
                    endcase
                end
                ST_APPLY: begin
                    op_reg <= OP_HOLD;
                    if (op_reg == OP_INS) begin
                        count_reg <= count_reg + CNT_W'(1);
                        used_reg  <= ins_used[32] ? 32'hFFFF_FFFF : ins_used[31:0];
                    end else begin
                        count_reg <= count_reg - CNT_W'(1);
                        used_reg  <= ({1'b0, used_reg} >= del_d) ?
                                     (used_reg - del_d[31:0]) : 32'd0;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {avail, used_reg, res_reg, ok_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_data_reg};

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg >= CNT_W'(1) && count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("table count out of range");
    a_op_only_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        op_reg != OP_HOLD |-> state_reg == ST_APPLY)
        else $error("table shift outside apply state");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> !s_tready)
        else $error("command accepted during scan");
    a_ok_has_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) && m_data_reg[0] |-> m_data_reg[32:1] != 32'd0)
        else $error("successful result with zero offset");
`endif

endmodule

/* rtl/core/aoha_cell.sv */
// One table entry of the allocator chain: holds a block, evaluates placement flags
// and passes entries and scan data to its neighbors. Depends on aoha_pkg.
module aoha_cell (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [aoha_pkg::IDX_W-1:0] idx,
    input  logic [31:0]             init_size,
    input  aoha_pkg::ctl_t          ctl,
    input  logic [31:0]             left_start,
    input  logic [31:0]             left_size,
    input  logic [31:0]             right_start,
    input  logic [31:0]             right_size,
    input  aoha_pkg::scan_t         right_scan,
    output logic [31:0]             start,
    output logic [31:0]             size,
    output aoha_pkg::scan_t         scan
);
    import aoha_pkg::*;

    logic [31:0] start_reg, start_next;
    logic [31:0] size_reg, size_next;
    scan_t       scan_reg, scan_next;
    logic [CNT_W-1:0] idx_c, idx_p1;
    logic        is_last, not_last, in_tab;
    logic [33:0] blk_end;
    logic [34:0] fit_end;
    logic [33:0] res_end;

    assign idx_c    = CNT_W'(idx);
    assign idx_p1   = idx_c + CNT_W'(1);
    assign is_last  = (idx_p1 == ctl.count);
    assign not_last = (idx_p1 < ctl.count);
    assign in_tab   = (idx_c < ctl.count);
    assign blk_end  = {2'b00, start_reg} + {2'b00, HDR32} + {2'b00, size_reg};
    assign fit_end  = {1'b0, blk_end} + {2'b00, ctl.need};
    assign res_end  = {2'b00, ctl.hdr} + {2'b00, ctl.req} + {2'b00, HDR32};

    always_comb begin
        start_next = start_reg;
        size_next  = size_reg;
        case (ctl.op)
            OP_INS: begin
                if (idx > ctl.pos) begin
                    start_next = left_start;
                    size_next  = left_size;
                end else if (idx == ctl.pos) begin
                    start_next = ctl.new_start;
                    size_next  = ctl.new_size;
                end
            end
            OP_DEL: begin
                if (idx >= ctl.pos) begin
                    start_next = right_start;
                    size_next  = right_size;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        scan_next = scan_reg;
        if (ctl.load) begin
            scan_next.gap        = not_last && (fit_end <= {3'b000, right_start});
            scan_next.alloc_last = is_last && (fit_end <= {3'b000, ctl.heap});
            scan_next.match      = (idx != '0) && in_tab && (start_reg == ctl.hdr);
            scan_next.between    = not_last && (start_reg < ctl.hdr) &&
                                   (ctl.hdr < right_start);
            scan_next.rok        = (blk_end <= {2'b00, ctl.hdr}) &&
                                   (is_last || (res_end <= {2'b00, right_start}));
            scan_next.last       = is_last;
            scan_next.blk_end    = blk_end;
            scan_next.size       = size_reg;
        end else if (ctl.shift) begin
            scan_next = right_scan;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            size_reg  <= init_size;
        end else begin
            start_reg <= start_next;
            size_reg  <= size_next;
        end
        scan_reg <= scan_next;
    end

    assign start = start_reg;
    assign size  = size_reg;
    assign scan  = scan_reg;

endmodule

/* sim/address_ordered_heap_allocator_core_tb.sv */
// Self-checking testbench for address_ordered_heap_allocator_core.
// Holds a scoreboard class that predicts every result transaction; needs aoha_pkg and the RTL.
`timescale 1ns / 1ps

module address_ordered_heap_allocator_core_tb;
    import aoha_pkg::*;

    typedef struct {
        logic        ok;
        logic [31:0] offset;
        logic [31:0] used;
        logic [31:0] avail;
    } heap_result_t;

    // Shadow of the allocator table; predicts each result and checks it in order.
    class heap_scoreboard;
        logic [31:0]  heap;
        logic [31:0]  starts [MAX_BLOCKS];
        logic [31:0]  sizes [MAX_BLOCKS];
        int           count;
        logic [31:0]  used;
        heap_result_t due [$];
        int           mismatches;

        function new();
            foreach (starts[i]) begin
                starts[i] = '0;
                sizes[i]  = '0;
            end
            heap       = HEAP_SIZE_RESET;
            sizes[0]   = FIRST_BLOCK_BYTES;
            count      = 1;
            used       = HDR32 + FIRST_BLOCK_BYTES;
            mismatches = 0;
        endfunction

        function logic [63:0] end_of(int i);
            return 64'(starts[i]) + 64'(HEADER_BYTES) + 64'(sizes[i]);
        endfunction

        function void insert(int pos, logic [31:0] s, logic [31:0] sz);
            logic [63:0] u;
            for (int k = count; k > pos; k--) begin
                starts[k] = starts[k-1];
                sizes[k]  = sizes[k-1];
            end
            starts[pos] = s;
            sizes[pos]  = sz;
            count++;
            u = 64'(used) + 64'(HEADER_BYTES) + 64'(sz);
            used = (u > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : u[31:0];
        endfunction

        function logic [31:0] place_block(logic [31:0] sz);
            logic [63:0] need;
            logic [31:0] s;
            int          last;
            need = 64'(HEADER_BYTES) + 64'(sz);
            if (count >= MAX_BLOCKS || count == 0) return '0;
            last = count - 1;
            if (end_of(last) + need <= 64'(heap)) begin
                s = 32'(end_of(last));
                insert(count, s, sz);
                return s + HDR32;
            end
            for (int i = 0; i < last; i++) begin
                if (end_of(i) + need <= 64'(starts[i+1])) begin
                    s = 32'(end_of(i));
                    insert(i + 1, s, sz);
                    return s + HDR32;
                end
            end
            return '0;
        endfunction

        function logic [31:0] free_block(logic [31:0] uoff);
            logic [31:0] hdr;
            logic [63:0] d;
            if (uoff < HDR32) return '0;
            hdr = uoff - HDR32;
            // The reserved first block is never a candidate.
            for (int i = 1; i < count; i++) begin
                if (starts[i] == hdr) begin
                    d = 64'(HEADER_BYTES) + 64'(sizes[i]);
                    used = (64'(used) >= d) ? 32'(64'(used) - d) : '0;
                    for (int k = i; k + 1 < count; k++) begin
                        starts[k] = starts[k+1];
                        sizes[k]  = sizes[k+1];
                    end
                    count--;
                    return uoff;
                end
            end
            return '0;
        endfunction

        function logic [31:0] reserve_block(logic [31:0] uoff, logic [31:0] sz);
            logic [31:0] hdr;
            if (count >= MAX_BLOCKS || count == 0) return '0;
            if (64'(uoff) + 64'(sz) >= 64'(heap)) return '0;
            if (uoff < HDR32) return '0;
            hdr = uoff - HDR32;
            for (int i = 0; i < count; i++) begin
                if (i + 1 < count) begin
                    if (starts[i] < hdr && hdr < starts[i+1]) begin
                        if (end_of(i) <= 64'(hdr) &&
                            64'(hdr) + 64'(sz) + 64'(HEADER_BYTES) <= 64'(starts[i+1])) begin
                            insert(i + 1, hdr, sz);
                            return uoff;
                        end
                        return '0;
                    end
                end else if (end_of(i) <= 64'(hdr)) begin
                    insert(i + 1, hdr, sz);
                    return uoff;
                end
            end
            return '0;
        endfunction

        // Called for every accepted command transaction.
        function void note(logic [1:0] cmd, logic [31:0] uoff, logic [31:0] req);
            heap_result_t r;
            logic [31:0]  res;
            case (cmd_t'(cmd))
                CMD_ALLOC:   res = place_block(req);
                CMD_FREE:    res = free_block(uoff);
                CMD_RESERVE: res = reserve_block(uoff, req);
                default:     res = '0;
            endcase
            r.ok     = (res != 0);
            r.offset = res;
            r.used   = used;
            r.avail  = (heap >= used) ? heap - used : '0;
            due.push_back(r);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%t mismatch: %s", $realtime, msg);
        endfunction

        // Called for every accepted result transaction.
        function void check(logic [103:0] d);
            heap_result_t r;
            if (due.size() == 0) begin
                flag($sformatf("result with nothing pending, data %h", d));
                return;
            end
            r = due.pop_front();
            if (d[0] !== r.ok)
                flag($sformatf("ok exp %0d got %0d", r.ok, d[0]));
            if (d[32:1] !== r.offset)
                flag($sformatf("offset exp %h got %h", r.offset, d[32:1]));
            if (d[64:33] !== r.used)
                flag($sformatf("used exp %h got %h", r.used, d[64:33]));
            if (d[96:65] !== r.avail)
                flag($sformatf("avail exp %h got %h", r.avail, d[96:65]));
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata   = '0;
    logic [1:0]   s_tuser   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [103:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [31:0]  cfg_wdata = '0;

    heap_scoreboard book;
    bit calm;          // phase without idling on either side
    bit hold_request;  // asks the receiver for one long stall

    address_ordered_heap_allocator_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Receiver: checks every result transaction and paces m_tready.
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) book.check(m_tdata);
            if (hold_request) begin
                hold_request = 0;
                stall = 400;
            end else if (!calm && stall == 0 && $urandom_range(0, 149) == 0) begin
                stall = $urandom_range(20, 60);
            end
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm ? 1'b1 : ($urandom_range(0, 3) != 0);
            end
        end
    end

    function automatic int pick_gap();
        if (calm) return 0;
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
        if ($urandom_range(0, 4) == 0) return $urandom_range(20, 60);
        return $urandom_range(3, 8);
    endfunction

    // Offers one command transaction and waits for it to be taken.
    task automatic send_cmd(cmd_t c, logic [31:0] uoff, logic [31:0] req);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {req, uoff};
        do @(posedge aclk); while (!s_tready);
        book.note(c, uoff, req);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Heap size is only changed once every pending result has come back.
    task automatic write_heap(logic [31:0] v);
        s_tvalid <= 1'b0;
        while (book.pending() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= v;
        do @(posedge aclk); while (!cfg_ready);
        book.heap = v;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] live_offset();
        if (book.count < 2) return HDR32 + FIRST_BLOCK_BYTES;
        return book.starts[$urandom_range(1, book.count - 1)] + HDR32;
    endfunction

    task automatic random_cmd(bit fill, bit big);
        int          r;
        logic [31:0] uo;
        logic [31:0] rq;
        r  = fill ? $urandom_range(0, 49) : $urandom_range(0, 99);
        uo = $urandom;
        rq = big ? $urandom : $urandom_range(0, 3000);
        if ($urandom_range(0, 9) == 0) rq = $urandom;
        if (r < 40) begin
            send_cmd(CMD_ALLOC, uo, rq);
        end else if (r < 70) begin
            if ($urandom_range(0, 4) != 0) uo = live_offset();
            else if ($urandom_range(0, 1) == 0) uo = $urandom_range(0, 40);
            send_cmd(CMD_FREE, uo, rq);
        end else if (r < 92) begin
            // Mostly aim just past an existing block so the gap checks get exercised.
            if ($urandom_range(0, 9) < 6)
                uo = 32'(book.end_of($urandom_range(0, book.count - 1))) + HDR32
                     + $urandom_range(0, 64) - 16;
            send_cmd(CMD_RESERVE, uo, rq);
        end else begin
            send_cmd(CMD_NONE, uo, rq);
        end
    endtask

    task automatic run_phase(logic [31:0] heap_val, int n, bit fill, bit big, bit quiet);
        write_heap(heap_val);
        calm = quiet;
        for (int i = 0; i < n; i++) random_cmd(fill, big);
    endtask

    initial begin
        logic [31:0] p;
        book = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_heap(HEAP_SIZE_RESET);
        // Directed checks at the reset heap size.
        send_cmd(CMD_ALLOC, '0, '0);
        send_cmd(CMD_ALLOC, 32'hFFFF_FFFF, 32'd100);
        send_cmd(CMD_ALLOC, '0, 32'hFFFF_FFFF);             // never fits
        send_cmd(CMD_FREE, HDR32, '0);                      // first block stays
        send_cmd(CMD_FREE, '0, '0);                         // below the header
        send_cmd(CMD_FREE, 32'd5, '0);
        send_cmd(CMD_RESERVE, 32'd10, 32'd8);               // below the header
        send_cmd(CMD_RESERVE, HEAP_SIZE_RESET - 32'd10, 32'd10); // touches the limit
        send_cmd(CMD_RESERVE, HEAP_SIZE_RESET - 32'd11, 32'd10); // just fits
        p = live_offset();
        send_cmd(CMD_RESERVE, p, 32'd4);                    // header on a header
        send_cmd(CMD_RESERVE, p + 32'd8, 32'd4);            // overlaps a block
        send_cmd(CMD_ALLOC, '0, 32'd500);                   // goes into a gap
        p = book.starts[1] + HDR32;
        send_cmd(CMD_FREE, p, '0);
        send_cmd(CMD_FREE, p, '0);                          // already gone
        send_cmd(CMD_RESERVE, p, 32'd0);                    // reuse the freed gap
        send_cmd(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_ALLOC, 32'hFFFF_FFFF, 32'd200);
        send_cmd(CMD_RESERVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        calm = 0;
        for (int i = 0; i < 130; i++) random_cmd(0, 0);
        // Fill the table while the receiver stalls, then keep pushing past full.
        hold_request = 1;
        for (int i = 0; i < 90; i++) random_cmd(1, 0);
        run_phase(32'd4096, 50, 0, 0, 0);           // below what is already used
        run_phase(32'hFFFF_FFFF, 140, 0, 1, 0);
        run_phase(32'd65536, 110, 0, 0, 1);
        run_phase(32'd8192, 40, 1, 0, 0);
        run_phase(HEAP_SIZE_RESET, 90, 0, 0, 0);
        s_tvalid <= 1'b0;

        while (book.pending() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (book.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
